/* rtl/rkm_pkg.sv */
// ----------------------------------------------------------------------------
// rkm_pkg
// shared types and constants of the textbook rsa key generation and modexp core
// ----------------------------------------------------------------------------
`default_nettype none

package rkm_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PRIME,
        ST_NMUL,
        ST_GCD,
        ST_LCM_DIV,
        ST_LCM_MUL,
        ST_E_TEST,
        ST_INV,
        ST_INV_MUL,
        ST_INV_UPD,
        ST_INV_FIX,
        ST_PW_INIT,
        ST_PW_LOOP,
        ST_PW_AMUL,
        ST_PW_ARED,
        ST_PW_BMUL,
        ST_PW_BRED,
        ST_FIN
    } rkm_state_t;

    // divider request and its completion
    typedef struct packed {
        logic start;
    } rkm_div_req_t;

    typedef struct packed {
        logic done;
    } rkm_div_rsp_t;

    localparam logic       KIND_KEYGEN  = 1'b0;
    localparam logic       KIND_DECRYPT = 1'b1;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_P_BAD   = 3'd1;
    localparam logic [2:0] STAT_Q_BAD   = 3'd2;
    localparam logic [2:0] STAT_NO_EXP  = 3'd3;
    localparam logic [2:0] STAT_ZERO_N  = 3'd4;

endpackage

`default_nettype wire

/* rtl/rkm_div.sv */
// ----------------------------------------------------------------------------
// rkm_div
// bit-serial restoring divider, 64-bit dividend by 32-bit divisor
// ----------------------------------------------------------------------------
`default_nettype none

module rkm_div (
    input  wire                  clk,
    input  wire                  rst_n,
    input  rkm_pkg::rkm_div_req_t req,
    input  wire  [63:0]          dividend,
    input  wire  [31:0]          divisor,
    output rkm_pkg::rkm_div_rsp_t rsp,
    output logic [31:0]          quotient,
    output logic [31:0]          remainder
);
    import rkm_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [63:0] dq_reg, dq_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rem_reg, dq_reg[63]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            rem_next  = '0;
            dsr_next  = divisor;
            // short dividends skip the upper half
            if (dividend[63:32] == 32'd0)
            begin
                dq_next  = {dividend[31:0], 32'd0};
                cnt_next = 7'd32;
            end
            else
            begin
                dq_next  = dividend;
                cnt_next = 7'd64;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[31:0] : trial[31:0];
            dq_next  = {dq_reg[62:0], ge};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done  = done_reg;
    assign quotient  = dq_reg[31:0];
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* rtl/rsa_keygen_and_modexp_core.sv */
// ----------------------------------------------------------------------------
// rsa_keygen_and_modexp_core
// textbook 32-bit rsa: key generation with encryption, or decryption
// ----------------------------------------------------------------------------
// One transaction in, one transaction out, nothing kept between items. Kind 0
// checks p and q by trial division, forms n = p*q and r = lcm(p-1, q-1),
// picks the smallest e >= 2 coprime to r, finds d = e^-1 mod r by extended
// Euclid and returns message^e mod n. Kind 1 returns message^d mod n with n
// and d taken from the input. All the arithmetic runs on one bit-serial
// divider (a dividend with a zero upper half skips that half) and one
// 32x32 multiplier under a small sequencer; s_tready is high only while the
// core is idle, so a new item is taken only once the last result is in the
// output register. Key generation is dominated by trial division, up to 254
// divisions per prime, plus the gcd, inverse and exponentiation passes. A
// finished result sits in the output register while the core goes back to
// idle and takes the next item.
`default_nettype none

module rsa_keygen_and_modexp_core (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    // message_value, prime_p, prime_q, modulus_in, exponent_in
    input  wire  [127:0] s_tdata,
    // kind
    input  wire  [0:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // modulus, public_exponent, private_exponent, result_value, status, zero pad
    output logic [135:0] m_tdata
);
    import rkm_pkg::*;

    // sequencer and handshake state
    rkm_state_t  state_reg, state_next;
    logic        wait_reg, wait_next;       // divider op in flight
    logic        m_tvalid_reg, m_tvalid_next;

    // item fields
    logic        kind_reg, kind_next;
    logic [31:0] msg_reg, msg_next;
    logic [15:0] p_reg, p_next;
    logic [15:0] q_reg, q_next;

    // working registers
    logic        chk_q_reg, chk_q_next;     // trial division on q
    logic        gcd_e_reg, gcd_e_next;     // gcd belongs to the e search
    logic [8:0]  i_reg, i_next;
    logic [16:0] sq_reg, sq_next;           // i squared
    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] n_reg, n_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] e_reg, e_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] oldr_reg, oldr_next;
    logic [31:0] curr_reg, curr_next;
    logic [31:0] qt_reg, qt_next;
    logic [31:0] tr_reg, tr_next;
    logic signed [33:0] olds_reg, olds_next;
    logic signed [33:0] curs_reg, curs_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] mod_reg, mod_next;
    logic [31:0] expo_reg, expo_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] res_reg, res_next;
    logic [2:0]  stat_reg, stat_next;
    logic [135:0] out_reg, out_next;

    // shared units
    rkm_div_req_t div_req;
    rkm_div_rsp_t div_rsp;
    logic [63:0]  div_dividend;
    logic [31:0]  div_divisor;
    logic [31:0]  div_quot;
    logic [31:0]  div_rem;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  product;

    // helpers
    logic [15:0]  cur_x;
    logic [31:0]  pm1;
    logic [31:0]  qm1;
    logic signed [33:0] curs_abs;
    logic signed [33:0] sprod;
    logic signed [33:0] term;
    logic signed [33:0] dfix;
    logic         keep_e;
    logic [31:0]  out_mod;

    rkm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .rsp       (div_rsp),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign cur_x    = chk_q_reg ? q_reg : p_reg;
    assign pm1      = {16'd0, p_reg} - 32'd1;
    assign qm1      = {16'd0, q_reg} - 32'd1;
    assign curs_abs = curs_reg[33] ? -curs_reg : curs_reg;
    assign sprod    = $signed(prod_reg[33:0]);
    assign term     = curs_reg[33] ? -sprod : sprod;
    assign dfix     = olds_reg[33] ? (olds_reg + $signed({2'b00, r_reg})) : olds_reg;
    assign product  = mul_a * mul_b;

    // divider operand selection
    always_comb
    begin
        div_dividend = '0;
        div_divisor  = mod_reg;
        case (state_reg)
            ST_PRIME:
            begin
                div_dividend = {48'd0, cur_x};
                div_divisor  = {23'd0, i_reg};
            end
            ST_GCD:
            begin
                div_dividend = {32'd0, x_reg};
                div_divisor  = y_reg;
            end
            ST_LCM_DIV:
            begin
                div_dividend = {32'd0, pm1};
                div_divisor  = x_reg;
            end
            ST_INV:
            begin
                div_dividend = {32'd0, oldr_reg};
                div_divisor  = curr_reg;
            end
            ST_PW_INIT:
            begin
                div_dividend = {32'd0, msg_reg};
            end
            ST_PW_ARED, ST_PW_BRED:
            begin
                div_dividend = prod_reg;
            end
            default:
            begin
                div_dividend = '0;
            end
        endcase
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_NMUL:
            begin
                mul_a = {16'd0, p_reg};
                mul_b = {16'd0, q_reg};
            end
            ST_LCM_MUL:
            begin
                mul_a = y_reg;
                mul_b = qm1;
            end
            ST_INV_MUL:
            begin
                mul_a = qt_reg;
                mul_b = curs_abs[31:0];
            end
            ST_PW_AMUL:
            begin
                mul_a = acc_reg;
                mul_b = b_reg;
            end
            ST_PW_BMUL:
            begin
                mul_a = b_reg;
                mul_b = b_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // output field selection
    assign keep_e  = (kind_reg == KIND_KEYGEN) && (stat_reg == STAT_OK);
    assign out_mod = (kind_reg == KIND_DECRYPT) ? mod_reg :
                     ((stat_reg == STAT_OK) || (stat_reg == STAT_NO_EXP)) ? n_reg : 32'd0;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        wait_next     = wait_reg;
        m_tvalid_next = m_tvalid_reg;
        kind_next     = kind_reg;
        msg_next      = msg_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        chk_q_next    = chk_q_reg;
        gcd_e_next    = gcd_e_reg;
        i_next        = i_reg;
        sq_next       = sq_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        n_next        = n_reg;
        r_next        = r_reg;
        e_next        = e_reg;
        d_next        = d_reg;
        oldr_next     = oldr_reg;
        curr_next     = curr_reg;
        qt_next       = qt_reg;
        tr_next       = tr_reg;
        olds_next     = olds_reg;
        curs_next     = curs_reg;
        prod_next     = prod_reg;
        mod_next      = mod_reg;
        expo_next     = expo_reg;
        acc_next      = acc_reg;
        b_next        = b_reg;
        res_next      = res_reg;
        stat_next     = stat_reg;
        out_next      = out_reg;
        div_req.start = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = s_tuser[0];
                    msg_next   = s_tdata[31:0];
                    p_next     = s_tdata[47:32];
                    q_next     = s_tdata[63:48];
                    mod_next   = s_tdata[95:64];
                    expo_next  = s_tdata[127:96];
                    res_next   = '0;
                    stat_next  = STAT_OK;
                    chk_q_next = 1'b0;
                    i_next     = 9'd2;
                    sq_next    = 17'd4;
                    wait_next  = 1'b0;
                    if (s_tuser[0] == KIND_DECRYPT)
                    begin
                        if (s_tdata[95:64] == 32'd0)
                        begin
                            stat_next  = STAT_ZERO_N;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_PW_INIT;
                        end
                    end
                    else
                    begin
                        state_next = ST_PRIME;
                    end
                end
            end

            // trial division of p, then q
            ST_PRIME:
            begin
                if (!wait_reg)
                begin
                    if (cur_x < 16'd2)
                    begin
                        stat_next  = chk_q_reg ? STAT_Q_BAD : STAT_P_BAD;
                        state_next = ST_FIN;
                    end
                    else if (sq_reg > {1'b0, cur_x})
                    begin
                        if (chk_q_reg)
                        begin
                            state_next = ST_NMUL;
                        end
                        else
                        begin
                            chk_q_next = 1'b1;
                            i_next     = 9'd2;
                            sq_next    = 17'd4;
                        end
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        wait_next     = 1'b1;
                    end
                end
                else if (div_rsp.done)
                begin
                    wait_next = 1'b0;
                    if (div_rem == 32'd0)
                    begin
                        stat_next  = chk_q_reg ? STAT_Q_BAD : STAT_P_BAD;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        // (i+1)^2 = i^2 + 2i + 1
                        sq_next = sq_reg + {7'd0, i_reg, 1'b1};
                        i_next  = i_reg + 9'd1;
                    end
                end
            end

            ST_NMUL:
            begin
                n_next     = product[31:0];
                x_next     = pm1;
                y_next     = qm1;
                gcd_e_next = 1'b0;
                state_next = ST_GCD;
            end

            // euclid on x, y; shared by lcm and e search
            ST_GCD:
            begin
                if (!wait_reg)
                begin
                    if (y_reg == 32'd0)
                    begin
                        if (!gcd_e_reg)
                        begin
                            state_next = ST_LCM_DIV;
                        end
                        else if (x_reg == 32'd1)
                        begin
                            oldr_next  = r_reg;
                            curr_next  = e_reg;
                            olds_next  = '0;
                            curs_next  = 34'sd1;
                            state_next = ST_INV;
                        end
                        else
                        begin
                            e_next     = e_reg + 32'd1;
                            state_next = ST_E_TEST;
                        end
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        wait_next     = 1'b1;
                    end
                end
                else if (div_rsp.done)
                begin
                    wait_next = 1'b0;
                    x_next    = y_reg;
                    y_next    = div_rem;
                end
            end

            ST_LCM_DIV:
            begin
                if (!wait_reg)
                begin
                    div_req.start = 1'b1;
                    wait_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    wait_next  = 1'b0;
                    y_next     = div_quot;
                    state_next = ST_LCM_MUL;
                end
            end

            ST_LCM_MUL:
            begin
                r_next     = product[31:0];
                e_next     = 32'd2;
                state_next = ST_E_TEST;
            end

            ST_E_TEST:
            begin
                if (e_reg >= r_reg)
                begin
                    stat_next  = STAT_NO_EXP;
                    state_next = ST_FIN;
                end
                else
                begin
                    x_next     = e_reg;
                    y_next     = r_reg;
                    gcd_e_next = 1'b1;
                    state_next = ST_GCD;
                end
            end

            // extended euclid for d
            ST_INV:
            begin
                if (!wait_reg)
                begin
                    if (curr_reg == 32'd0)
                    begin
                        state_next = ST_INV_FIX;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        wait_next     = 1'b1;
                    end
                end
                else if (div_rsp.done)
                begin
                    wait_next  = 1'b0;
                    qt_next    = div_quot;
                    tr_next    = div_rem;
                    state_next = ST_INV_MUL;
                end
            end

            ST_INV_MUL:
            begin
                prod_next  = product;
                state_next = ST_INV_UPD;
            end

            ST_INV_UPD:
            begin
                oldr_next  = curr_reg;
                curr_next  = tr_reg;
                olds_next  = curs_reg;
                curs_next  = olds_reg - term;
                state_next = ST_INV;
            end

            ST_INV_FIX:
            begin
                d_next     = dfix[31:0];
                mod_next   = n_reg;
                expo_next  = e_reg;
                state_next = ST_PW_INIT;
            end

            // square and multiply
            ST_PW_INIT:
            begin
                if (!wait_reg)
                begin
                    acc_next      = (mod_reg == 32'd1) ? 32'd0 : 32'd1;
                    div_req.start = 1'b1;
                    wait_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    wait_next  = 1'b0;
                    b_next     = div_rem;
                    state_next = ST_PW_LOOP;
                end
            end

            ST_PW_LOOP:
            begin
                if (expo_reg == 32'd0)
                begin
                    res_next   = acc_reg;
                    state_next = ST_FIN;
                end
                else if (expo_reg[0])
                begin
                    state_next = ST_PW_AMUL;
                end
                else
                begin
                    state_next = ST_PW_BMUL;
                end
            end

            ST_PW_AMUL:
            begin
                prod_next  = product;
                state_next = ST_PW_ARED;
            end

            ST_PW_ARED:
            begin
                if (!wait_reg)
                begin
                    div_req.start = 1'b1;
                    wait_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    wait_next  = 1'b0;
                    acc_next   = div_rem;
                    state_next = ST_PW_BMUL;
                end
            end

            ST_PW_BMUL:
            begin
                prod_next  = product;
                state_next = ST_PW_BRED;
            end

            ST_PW_BRED:
            begin
                if (!wait_reg)
                begin
                    div_req.start = 1'b1;
                    wait_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    wait_next  = 1'b0;
                    b_next     = div_rem;
                    expo_next  = {1'b0, expo_reg[31:1]};
                    state_next = ST_PW_LOOP;
                end
            end

            // hand the result to the output register once it is free
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next = {5'd0, stat_reg, res_reg,
                                keep_e ? d_reg : 32'd0,
                                keep_e ? e_reg : 32'd0,
                                out_mod};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wait_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wait_reg     <= wait_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        msg_reg   <= msg_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        chk_q_reg <= chk_q_next;
        gcd_e_reg <= gcd_e_next;
        i_reg     <= i_next;
        sq_reg    <= sq_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        n_reg     <= n_next;
        r_reg     <= r_next;
        e_reg     <= e_next;
        d_reg     <= d_next;
        oldr_reg  <= oldr_next;
        curr_reg  <= curr_next;
        qt_reg    <= qt_next;
        tr_reg    <= tr_next;
        olds_reg  <= olds_next;
        curs_reg  <= curs_next;
        prod_reg  <= prod_next;
        mod_reg   <= mod_next;
        expo_reg  <= expo_next;
        acc_reg   <= acc_next;
        b_reg     <= b_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
        out_reg   <= out_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // a new transaction always starts a multi-cycle run
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("core ready right after accepting a transaction");

    // status codes stay in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[130:128] == STAT_OK || m_tdata[130:128] == STAT_P_BAD ||
                      m_tdata[130:128] == STAT_Q_BAD || m_tdata[130:128] == STAT_NO_EXP ||
                      m_tdata[130:128] == STAT_ZERO_N))
        else $error("status out of range");

    // rejected primes give an all-zero result
    a_bad_prime_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[130:128] == STAT_P_BAD || m_tdata[130:128] == STAT_Q_BAD))
        |-> (m_tdata[127:0] == 128'd0))
        else $error("nonzero fields with a rejected prime");

    // the divider is only started when no operation is pending
    a_div_single: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> (wait_reg && !div_req.start))
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

/* sim/rsa_keygen_and_modexp_core_tb.sv */
// ----------------------------------------------------------------------------
// rsa_keygen_and_modexp_core_tb
// self-checking bench for the textbook rsa key generation and modexp core
// ----------------------------------------------------------------------------
// Drives a table of directed transactions and then random ones, mostly with
// real primes or keys generated on the fly, predicts each result in the bench or
// takes a typed-in one, and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_keygen_and_modexp_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rkm_pkg::*;

    localparam int N_RANDOM    = 80;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic        kind;
        logic [31:0] msg;
        logic [15:0] p;
        logic [15:0] q;
        logic [31:0] n_in;
        logic [31:0] d_in;
    } rsa_req_t;

    typedef struct packed {
        logic [31:0] n;
        logic [31:0] e;
        logic [31:0] d;
        logic [31:0] value;
        logic [2:0]  status;
    } rsa_rsp_t;

    // directed row: request, and an optional typed-in expected result
    typedef struct packed {
        rsa_req_t req;
        logic     has_exp;
        rsa_rsp_t exp;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // message_value, prime_p, prime_q, modulus_in, exponent_in
    logic [127:0] s_tdata;
    // kind
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // modulus, public_exponent, private_exponent, result_value, status, zero pad
    logic [135:0] m_tdata;

    rsa_rsp_t     pending_rsp[$];
    int           n_errors;
    int           n_checked;
    int           n_sent;
    int           cycle_cnt;
    int           src_idle_pct;
    int           dst_idle_pct;

    rsa_keygen_and_modexp_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // arithmetic helpers of the predictor
    // ------------------------------------------------------------------------
    function automatic bit is_prime(input logic [31:0] x);
        logic [31:0] i;
        if (x < 2)
            return 1'b0;
        for (i = 2; i * i <= x; i++)
            if (x % i == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [63:0] gcd_u64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [31:0] inverse_mod(input longint e, input longint r);
        longint old_r, cur_r, old_s, cur_s, qt, tr, ts;
        old_r = r;
        cur_r = e;
        old_s = 0;
        cur_s = 1;
        while (cur_r != 0)
        begin
            qt    = old_r / cur_r;
            tr    = old_r - qt * cur_r;
            ts    = old_s - qt * cur_s;
            old_r = cur_r;
            cur_r = tr;
            old_s = cur_s;
            cur_s = ts;
        end
        old_s = old_s % r;
        if (old_s < 0)
            old_s += r;
        return old_s[31:0];
    endfunction

    function automatic logic [31:0] pow_mod(input logic [31:0] base, input logic [31:0] expo,
                                            input logic [31:0] m);
        logic [63:0] acc, b;
        acc = 64'd1 % m;
        b   = {32'd0, base} % m;
        while (expo != 0)
        begin
            if (expo[0])
                acc = (acc * b) % m;
            b    = (b * b) % m;
            expo = expo >> 1;
        end
        return acc[31:0];
    endfunction

    // predicts the one result a request produces
    function automatic rsa_rsp_t rsa_predict(input rsa_req_t req);
        rsa_rsp_t    rsp;
        logic [63:0] a, b, r, e;
        bit          found;
        rsp = '0;
        if (req.kind == KIND_DECRYPT)
        begin
            rsp.n = req.n_in;
            if (req.n_in == 0)
                rsp.status = STAT_ZERO_N;
            else
                rsp.value = pow_mod(req.msg, req.d_in, req.n_in);
        end
        else if (!is_prime({16'd0, req.p}))
            rsp.status = STAT_P_BAD;
        else if (!is_prime({16'd0, req.q}))
            rsp.status = STAT_Q_BAD;
        else
        begin
            a     = req.p - 1;
            b     = req.q - 1;
            r     = a / gcd_u64(a, b) * b;
            rsp.n = req.p * req.q;
            found = 1'b0;
            for (e = 2; e < r; e++)
                if (gcd_u64(e, r) == 1)
                begin
                    found = 1'b1;
                    break;
                end
            if (!found)
                rsp.status = STAT_NO_EXP;
            else
            begin
                rsp.e     = e[31:0];
                rsp.d     = inverse_mod(e, r);
                rsp.value = pow_mod(req.msg, rsp.e, rsp.n);
                rsp.status = STAT_OK;
            end
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [15:0] rand_prime(input int lo, input int hi);
        logic [15:0] x;
        do
            x = 16'($urandom_range(hi, lo));
        while (!is_prime({16'd0, x}));
        return x;
    endfunction

    function automatic rsa_req_t mk_req(input logic kind, input logic [31:0] msg,
                                        input logic [15:0] p, input logic [15:0] q,
                                        input logic [31:0] n_in, input logic [31:0] d_in);
        rsa_req_t req;
        req.kind = kind;
        req.msg  = msg;
        req.p    = p;
        req.q    = q;
        req.n_in = n_in;
        req.d_in = d_in;
        return req;
    endfunction

    function automatic rsa_rsp_t mk_rsp(input logic [31:0] n, input logic [31:0] e,
                                        input logic [31:0] d, input logic [31:0] v,
                                        input logic [2:0] st);
        rsa_rsp_t rsp;
        rsp.n      = n;
        rsp.e      = e;
        rsp.d      = d;
        rsp.value  = v;
        rsp.status = st;
        return rsp;
    endfunction

    // mostly small primes keep the trial division short; a few big ones
    function automatic rsa_req_t random_req();
        rsa_req_t    req;
        rsa_rsp_t    key;
        int          pick;
        logic [15:0] p, q;
        pick = $urandom_range(99);
        req  = mk_req(1'b0, $urandom, 16'($urandom), 16'($urandom), $urandom, $urandom);
        if (pick < 40)
        begin
            p = (pick < 5) ? rand_prime(30000, 65535) : rand_prime(2, 3000);
            q = (pick < 8) ? rand_prime(30000, 65535) : rand_prime(2, 3000);
            req.p = p;
            req.q = q;
        end
        else if (pick < 70)
        begin
            // decrypt a ciphertext with a freshly generated key
            p   = rand_prime(3, 3000);
            q   = rand_prime(3, 3000);
            key = rsa_predict(mk_req(KIND_KEYGEN, 0, p, q, 0, 0));
            req.kind = KIND_DECRYPT;
            req.n_in = key.n;
            req.d_in = key.d;
            if (key.n != 0)
                req.msg = pow_mod($urandom, key.e, key.n);
        end
        else if (pick < 85)
        begin
            req.kind = KIND_DECRYPT;
            if (pick < 75)
                req.n_in = $urandom_range(3);
        end
        else
        begin
            // noise: mostly composite primes or arbitrary values
            req.kind = KIND_KEYGEN;
            req.p    = (pick < 92) ? 16'($urandom_range(2000)) : 16'($urandom);
            req.q    = 16'($urandom_range(2000));
        end
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // driver: one transaction, with random leading gap
    // ------------------------------------------------------------------------
    task automatic send_req(input rsa_req_t req, input bit has_exp, input rsa_rsp_t exp);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {req.d_in, req.n_in, req.q, req.p, req.msg};
        s_tuser  <= req.kind;
        pending_rsp.push_back(has_exp ? exp : rsa_predict(req));
        do
            @(posedge clk);
        while (!s_tready);
        n_sent++;
    endtask

    // receiver: random back pressure, checks each result transaction
    always @(posedge clk)
    begin
        rsa_rsp_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = mk_rsp(m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                             m_tdata[127:96], m_tdata[130:128]);
                if (pending_rsp.size() == 0)
                begin
                    $error("result with nothing pending: %h", got);
                    n_errors++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    n_checked++;
                    if (got.n != want.n)
                    begin
                        $error("modulus exp %h got %h", want.n, got.n);
                        n_errors++;
                    end
                    if (got.e != want.e)
                    begin
                        $error("public_exponent exp %h got %h", want.e, got.e);
                        n_errors++;
                    end
                    if (got.d != want.d)
                    begin
                        $error("private_exponent exp %h got %h", want.d, got.d);
                        n_errors++;
                    end
                    if (got.value != want.value)
                    begin
                        $error("result_value exp %h got %h", want.value, got.value);
                        n_errors++;
                    end
                    if (got.status != want.status)
                    begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        n_errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        dir_row_t dir_tab[$];
        rsa_rsp_t none;
        int       k, phase;
        none         = '0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        n_errors     = 0;
        n_checked    = 0;
        n_sent       = 0;
        cycle_cnt    = 0;
        src_idle_pct = 16;
        dst_idle_pct = 87;

        // extremes and error codes typed in; the rest predicted
        dir_tab.push_back('{mk_req(KIND_KEYGEN, 32'h0, 16'd0, 16'd7, 0, 0), 1'b1,
                            mk_rsp(0, 0, 0, 0, STAT_P_BAD)});
        dir_tab.push_back('{mk_req(KIND_KEYGEN, 32'h5, 16'd1, 16'd1, 0, 0), 1'b1,
                            mk_rsp(0, 0, 0, 0, STAT_P_BAD)});
        dir_tab.push_back('{mk_req(KIND_KEYGEN, 32'h5, 16'd7, 16'd1, 0, 0), 1'b1,
                            mk_rsp(0, 0, 0, 0, STAT_Q_BAD)});
        dir_tab.push_back('{mk_req(KIND_KEYGEN, '1, 16'hFFFF, 16'hFFFF, '1, '1), 1'b1,
                            mk_rsp(0, 0, 0, 0, STAT_P_BAD)});
        dir_tab.push_back('{mk_req(KIND_KEYGEN, '1, 16'd65521, 16'd65535, 0, 0), 1'b1,
                            mk_rsp(0, 0, 0, 0, STAT_Q_BAD)});
        // r <= 2: no usable exponent, n still reported
        dir_tab.push_back('{mk_req(KIND_KEYGEN, 32'h9, 16'd2, 16'd2, 0, 0), 1'b1,
                            mk_rsp(4, 0, 0, 0, STAT_NO_EXP)});
        dir_tab.push_back('{mk_req(KIND_KEYGEN, 32'h9, 16'd3, 16'd2, 0, 0), 1'b1,
                            mk_rsp(6, 0, 0, 0, STAT_NO_EXP)});
        dir_tab.push_back('{mk_req(KIND_KEYGEN, 32'h9, 16'd3, 16'd3, 0, 0), 1'b1,
                            mk_rsp(9, 0, 0, 0, STAT_NO_EXP)});
        dir_tab.push_back('{mk_req(KIND_DECRYPT, '1, '1, '1, 32'd0, '1), 1'b1,
                            mk_rsp(0, 0, 0, 0, STAT_ZERO_N)});
        // modulus one reduces everything to zero
        dir_tab.push_back('{mk_req(KIND_DECRYPT, '1, 0, 0, 32'd1, '1), 1'b1,
                            mk_rsp(1, 0, 0, 0, STAT_OK)});
        // exponent zero gives one
        dir_tab.push_back('{mk_req(KIND_DECRYPT, 32'h1234, 0, 0, 32'd77, 32'd0), 1'b1,
                            mk_rsp(77, 0, 0, 1, STAT_OK)});
        dir_tab.push_back('{mk_req(KIND_DECRYPT, 32'h0, 0, 0, '1, '1), 1'b1,
                            mk_rsp('1, 0, 0, 0, STAT_OK)});
        dir_tab.push_back('{mk_req(KIND_KEYGEN, 32'd65, 16'd61, 16'd53, 0, 0), 1'b0, none});
        dir_tab.push_back('{mk_req(KIND_KEYGEN, 32'd65, 16'd2, 16'd5, 0, 0), 1'b0, none});
        dir_tab.push_back('{mk_req(KIND_KEYGEN, '1, 16'd65521, 16'd65519, '1, '1), 1'b0, none});
        dir_tab.push_back('{mk_req(KIND_KEYGEN, 32'h8000_0001, 16'd65521, 16'd2, 0, 0),
                            1'b0, none});
        dir_tab.push_back('{mk_req(KIND_DECRYPT, 32'hFFFF_FFFE, 16'hFFFF, 16'hFFFF, '1, '1),
                            1'b0, none});
        dir_tab.push_back('{mk_req(KIND_DECRYPT, 32'd2790, 0, 0, 32'd3233, 32'd413),
                            1'b0, none});
        dir_tab.push_back('{mk_req(KIND_DECRYPT, 32'h5555_AAAA, 16'h5555, 16'hAAAA,
                            32'hAAAA_5555, 32'h5555_AAAA), 1'b0, none});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_req(dir_tab[i].req, dir_tab[i].has_exp, dir_tab[i].exp);

        // three idling phases across the random part
        for (phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 87 : 0;
            dst_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 16 : 0;
            for (k = 0; k < N_RANDOM / 3 + 1; k++)
                send_req(random_req(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d transactions, checked %0d results, %0d mismatches",
                 n_sent, n_checked, n_errors);
        $display("covered prime rejects, missing exponent, zero modulus, keygen and decrypt");
        if (n_errors == 0 && pending_rsp.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
